// File: hw/rtl/id3v2_frame_parser_macros.svh
// Assertion helpers for the ID3v2 frame parser.
`ifndef ID3V2_FRAME_PARSER_MACROS_SVH
`define ID3V2_FRAME_PARSER_MACROS_SVH

// Checked at every clock edge outside reset.
`define ID3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ID3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/id3_pkg.sv
package id3_pkg;

  localparam logic [7:0]  VersionReset = 8'd3;
  localparam logic [6:0]  SyncsafeMask = 7'h7F;
  localparam int unsigned ExtFlagBit   = 6;
  localparam logic [3:0]  LastHdrByte  = 4'd9;   // frameHeaderSize - 1
  localparam logic [3:0]  LastIdByte   = 4'd3;
  localparam logic [3:0]  FirstSzByte  = 4'd4;
  localparam logic [3:0]  LastSzByte   = 4'd7;
  localparam logic [3:0]  VersionByte  = 4'd3;
  localparam logic [3:0]  FlagsByte    = 4'd5;
  localparam logic [3:0]  FirstTagSz   = 4'd6;

  localparam logic [31:0] IdTitle  = 32'h5449_5432;  // TIT2
  localparam logic [31:0] IdAlbum  = 32'h5441_4C42;  // TALB
  localparam logic [31:0] IdArtist = 32'h5450_4531;  // TPE1
  localparam logic [31:0] IdLength = 32'h544C_454E;  // TLEN
  localparam logic [31:0] IdYear   = 32'h5459_4552;  // TYER
  localparam logic [31:0] IdSize   = 32'h5453_495A;  // TSIZ

  typedef enum logic [2:0] {
    ST_PAYLOAD     = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_TAG_DONE    = 3'd3,
    ST_TRUNCATED   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FK_TITLE  = 3'd0,
    FK_ALBUM  = 3'd1,
    FK_ARTIST = 3'd2,
    FK_LENGTH = 3'd3,
    FK_YEAR   = 3'd4,
    FK_SIZE   = 3'd5,
    FK_OTHER  = 3'd6
  } frame_kind_e;

  typedef enum logic [6:0] {
    PH_HEADER   = 7'b000_0001,
    PH_EXT_LEN  = 7'b000_0010,
    PH_EXT_SKIP = 7'b000_0100,
    PH_FR_HDR   = 7'b000_1000,
    PH_FR_DATA  = 7'b001_0000,
    PH_PADDING  = 7'b010_0000,
    PH_DONE     = 7'b100_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    frame_kind_e frame_kind;
    logic [7:0]  payload_byte;
    logic        frame_end;
  } out_item_t;

  // "ID3" magic, one byte per header position
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd0:    val = 8'h49;
      2'd1:    val = 8'h44;
      default: val = 8'h33;
    endcase
    return val;
  endfunction

  function automatic frame_kind_e kind_of(input logic [31:0] id);
    frame_kind_e k;
    case (id)
      IdTitle:  k = FK_TITLE;
      IdAlbum:  k = FK_ALBUM;
      IdArtist: k = FK_ARTIST;
      IdLength: k = FK_LENGTH;
      IdYear:   k = FK_YEAR;
      IdSize:   k = FK_SIZE;
      default:  k = FK_OTHER;
    endcase
    return k;
  endfunction

endpackage

// File: hw/rtl/id3v2_frame_parser.sv
// ID3v2 tag frame parser.
// Input channel: one file byte per transaction (in_valid_i / in_stall_o), with
// start_of_file restarting the parser and end_of_file marking the last byte.
// Output channel: at most one result per input byte (out_valid_o / out_stall_i):
// a frame text byte with its frame kind and end-of-frame mark, or a status
// (bad magic, bad version, tag done, truncated). Header, extended header, frame
// headers, encoding bytes and padding produce no frame text byte.
// Config channel: cfg_valid_i / cfg_ready_o writes the accepted major version;
// ready is always high, write only while the parser is idle.
// Path: an accepted byte is held in the input register, then the parse state
// update writes its result into the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the parse state update.
// Reset: parse state goes to the header phase, version register to 3, both
// pipeline registers empty. Without a start mark the first byte is a header byte.
// Stall: a held result blocks the parse step; the input register then fills and
// in_stall_o rises, so at most two bytes sit in the block while stalled.
`include "id3v2_frame_parser_macros.svh"

module id3v2_frame_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  id3_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output id3_pkg::out_item_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_accepted_version_i
);

  logic               in_vld_q;
  id3_pkg::in_item_t  in_item_q;
  logic               out_vld_q;
  id3_pkg::out_item_t out_item_q;
  logic [7:0]         version_q;

  id3_pkg::phase_e phase_q, phase_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [27:0]     tag_left_q, tag_left_d;
  logic [31:0]     frame_left_q, frame_left_d;
  logic [31:0]     frame_id_q, frame_id_d;
  logic            ext_flag_q, ext_flag_d;
  logic [31:0]     skip_left_q, skip_left_d;

  logic               out_ready;
  logic               step;
  logic               res_vld;
  id3_pkg::out_item_t res;

  assign out_ready   = !out_vld_q || !out_stall_i;
  assign step        = in_vld_q && out_ready;
  assign in_stall_o  = in_vld_q && !out_ready;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_item_q;

  always_comb begin
    id3_pkg::phase_e ph;
    logic [3:0]  c;
    logic [27:0] tag;
    logic [27:0] tag_dec;
    logic [7:0]  b;
    logic        clean;

    b  = in_item_q.file_byte;
    ph = in_item_q.start_of_file ? id3_pkg::PH_HEADER : phase_q;
    c  = in_item_q.start_of_file ? 4'd0 : cnt_q;
    tag = in_item_q.start_of_file ? 28'd0 : tag_left_q;
    tag_dec = (tag != 28'd0) ? tag - 28'd1 : tag;

    phase_d      = ph;
    cnt_d        = c;
    tag_left_d   = tag;
    frame_left_d = in_item_q.start_of_file ? 32'd0 : frame_left_q;
    frame_id_d   = in_item_q.start_of_file ? 32'd0 : frame_id_q;
    ext_flag_d   = in_item_q.start_of_file ? 1'b0 : ext_flag_q;
    skip_left_d  = in_item_q.start_of_file ? 32'd0 : skip_left_q;

    res_vld          = 1'b0;
    res.status       = id3_pkg::ST_PAYLOAD;
    res.frame_kind   = id3_pkg::FK_TITLE;
    res.payload_byte = 8'd0;
    res.frame_end    = 1'b0;

    case (ph)
      id3_pkg::PH_HEADER: begin
        if (c < 4'd3 && b != id3_pkg::magic_byte(c[1:0])) begin
          res.status = id3_pkg::ST_BAD_MAGIC;
          res_vld    = 1'b1;
          phase_d    = id3_pkg::PH_DONE;
        end else if (c == id3_pkg::VersionByte && b != version_q) begin
          res.status = id3_pkg::ST_BAD_VERSION;
          res_vld    = 1'b1;
          phase_d    = id3_pkg::PH_DONE;
        end else begin
          if (c == id3_pkg::FlagsByte) begin
            ext_flag_d = b[id3_pkg::ExtFlagBit];
          end
          if (c == id3_pkg::FirstTagSz) begin
            tag_left_d = {21'd0, b[6:0] & id3_pkg::SyncsafeMask};
          end else if (c > id3_pkg::FirstTagSz) begin
            tag_left_d = {tag[20:0], b[6:0] & id3_pkg::SyncsafeMask};
          end
          if (c >= id3_pkg::LastHdrByte) begin
            cnt_d       = 4'd0;
            skip_left_d = 32'd0;
            phase_d     = ext_flag_d ? id3_pkg::PH_EXT_LEN : id3_pkg::PH_FR_HDR;
          end else begin
            cnt_d = c + 4'd1;
          end
        end
      end
      id3_pkg::PH_EXT_LEN: begin
        tag_left_d  = tag_dec;
        skip_left_d = {skip_left_d[23:0], b};
        if (c >= 4'd3) begin
          cnt_d   = 4'd0;
          phase_d = (skip_left_d != 32'd0) ? id3_pkg::PH_EXT_SKIP : id3_pkg::PH_FR_HDR;
        end else begin
          cnt_d = c + 4'd1;
        end
      end
      id3_pkg::PH_EXT_SKIP: begin
        tag_left_d = tag_dec;
        if (skip_left_d != 32'd0) begin
          skip_left_d = skip_left_d - 32'd1;
        end
        if (skip_left_d == 32'd0) begin
          cnt_d   = 4'd0;
          phase_d = id3_pkg::PH_FR_HDR;
        end
      end
      id3_pkg::PH_FR_HDR: begin
        if (c == 4'd0 && tag == 28'd0) begin
          res.status = id3_pkg::ST_TAG_DONE;
          res_vld    = 1'b1;
          phase_d    = id3_pkg::PH_DONE;
        end else begin
          tag_left_d = tag_dec;
          if (c == 4'd0) begin
            frame_id_d = {24'd0, b};
          end else if (c <= id3_pkg::LastIdByte) begin
            frame_id_d = {frame_id_d[23:0], b};
          end else if (c == id3_pkg::FirstSzByte) begin
            frame_left_d = {24'd0, b};
          end else if (c <= id3_pkg::LastSzByte) begin
            frame_left_d = {frame_left_d[23:0], b};
          end
          // an all-zero id opens padding
          if (c == id3_pkg::LastIdByte && frame_id_d == 32'd0) begin
            cnt_d   = 4'd0;
            phase_d = id3_pkg::PH_PADDING;
          end else if (c >= id3_pkg::LastHdrByte) begin
            cnt_d   = 4'd0;
            phase_d = (frame_left_d != 32'd0) ? id3_pkg::PH_FR_DATA : id3_pkg::PH_FR_HDR;
          end else begin
            cnt_d = c + 4'd1;
          end
        end
      end
      id3_pkg::PH_FR_DATA: begin
        tag_left_d = tag_dec;
        if (frame_left_d != 32'd0) begin
          frame_left_d = frame_left_d - 32'd1;
        end
        // drop the encoding byte, emit the rest
        if (c == 4'd0) begin
          cnt_d = 4'd1;
        end else begin
          res.frame_kind   = id3_pkg::kind_of(frame_id_d);
          res.payload_byte = b;
          res.frame_end    = (frame_left_d == 32'd0);
          res_vld          = 1'b1;
        end
        if (frame_left_d == 32'd0) begin
          cnt_d   = 4'd0;
          phase_d = id3_pkg::PH_FR_HDR;
        end
      end
      id3_pkg::PH_PADDING: begin
        if (tag == 28'd0) begin
          res.status = id3_pkg::ST_TAG_DONE;
          res_vld    = 1'b1;
          phase_d    = id3_pkg::PH_DONE;
        end else begin
          tag_left_d = tag_dec;
        end
      end
      default: begin
        phase_d = id3_pkg::PH_DONE;
      end
    endcase

    clean = (tag_left_d == 28'd0) &&
            ((phase_d == id3_pkg::PH_FR_HDR && cnt_d == 4'd0) ||
             phase_d == id3_pkg::PH_PADDING);
    if (in_item_q.end_of_file && phase_d != id3_pkg::PH_DONE &&
        (!res_vld || res.status == id3_pkg::ST_PAYLOAD) && !clean) begin
      res.status       = id3_pkg::ST_TRUNCATED;
      res.frame_kind   = id3_pkg::FK_TITLE;
      res.payload_byte = 8'd0;
      res.frame_end    = 1'b0;
      res_vld          = 1'b1;
      phase_d          = id3_pkg::PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      version_q    <= id3_pkg::VersionReset;
      phase_q      <= id3_pkg::PH_HEADER;
      cnt_q        <= 4'd0;
      tag_left_q   <= 28'd0;
      frame_left_q <= 32'd0;
      frame_id_q   <= 32'd0;
      ext_flag_q   <= 1'b0;
      skip_left_q  <= 32'd0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_ready) begin
        out_vld_q <= step && res_vld;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        version_q <= cfg_accepted_version_i;
      end
      if (step) begin
        phase_q      <= phase_d;
        cnt_q        <= cnt_d;
        tag_left_q   <= tag_left_d;
        frame_left_q <= frame_left_d;
        frame_id_q   <= frame_id_d;
        ext_flag_q   <= ext_flag_d;
        skip_left_q  <= skip_left_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_data_i;
    end
    if (step && res_vld) begin
      out_item_q <= res;
    end
  end

  `ID3_ASSERT(a_status_fields_zero, out_valid_o && out_data_o.status != id3_pkg::ST_PAYLOAD |-> out_data_o.payload_byte == 8'd0 && out_data_o.frame_end == 1'b0 && out_data_o.frame_kind == id3_pkg::FK_TITLE, "status result carries payload fields")
  `ID3_ASSERT(a_counter_range, cnt_q <= id3_pkg::LastHdrByte, "byte counter past header length")
  `ID3_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> out_vld_q && out_stall_i && in_vld_q, "input stalled without a held result")
  `ID3_ASSERT(a_status_to_done, step && res_vld && res.status != id3_pkg::ST_PAYLOAD |=> phase_q == id3_pkg::PH_DONE, "status result without entering done")

endmodule
